>>> rtl/rbc_pkg.sv
// rbc_pkg: shared types and constants of the retry backoff controller.
// Holds the result outcome codes, configuration register indexes and fixed field widths.
// No dependencies.
package rbc_pkg;

    localparam int LIMIT_W  = 5;   // retry_limit
    localparam int GROWTH_W = 16;  // growth_factor, unsigned Q8.8
    localparam int JIT_W    = 9;   // jitter_span, unsigned Q1.8
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OUT_RETRY     = 2'd0,
        OUT_SUCCESS   = 2'd1,
        OUT_BLOCKED   = 2'd2,
        OUT_EXHAUSTED = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETRY_LIMIT = 3'd0,
        CFG_FIRST_DELAY = 3'd1,
        CFG_DELAY_CAP   = 3'd2,
        CFG_GROWTH      = 3'd3,
        CFG_JITTER_SPAN = 3'd4,
        CFG_BREAKER_EN  = 3'd5
    } t_cfg_idx;

endpackage

>>> rtl/rbc_cfg_regs.sv
// rbc_cfg_regs: configuration register file of the retry backoff controller.
// Decodes write transactions from the config channel into six registers.
// Depends on rbc_pkg.
module rbc_cfg_regs import rbc_pkg::*; #(
    parameter int DELAY_BITS = 16,
    parameter int CFG_W      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic [LIMIT_W-1:0]    o_retry_limit,
    output logic [DELAY_BITS-1:0] o_first_delay,
    output logic [DELAY_BITS-1:0] o_delay_cap,
    output logic [GROWTH_W-1:0]   o_growth,
    output logic [JIT_W-1:0]      o_jitter_span,
    output logic                  o_breaker_en
);

    logic [LIMIT_W-1:0]    r_retry_limit;
    logic [DELAY_BITS-1:0] r_first_delay;
    logic [DELAY_BITS-1:0] r_delay_cap;
    logic [GROWTH_W-1:0]   r_growth;
    logic [JIT_W-1:0]      r_jitter_span;
    logic                  r_breaker_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= LIMIT_W'(5);
            r_first_delay <= DELAY_BITS'(10);
            r_delay_cap   <= DELAY_BITS'(5000);
            r_growth      <= GROWTH_W'(512);
            r_jitter_span <= JIT_W'(64);
            r_breaker_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_FIRST_DELAY: r_first_delay <= i_cfg_data[DELAY_BITS-1:0];
                CFG_DELAY_CAP:   r_delay_cap   <= i_cfg_data[DELAY_BITS-1:0];
                CFG_GROWTH:      r_growth      <= i_cfg_data[GROWTH_W-1:0];
                CFG_JITTER_SPAN: r_jitter_span <= i_cfg_data[JIT_W-1:0];
                CFG_BREAKER_EN:  r_breaker_en  <= i_cfg_data[0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_retry_limit = r_retry_limit;
    assign o_first_delay = r_first_delay;
    assign o_delay_cap   = r_delay_cap;
    assign o_growth      = r_growth;
    assign o_jitter_span = r_jitter_span;
    assign o_breaker_en  = r_breaker_en;

endmodule

>>> rtl/rbc_serial_mult.sv
// rbc_serial_mult: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Multiplicand i_a must be held stable while busy; i_b is captured at start.
// No dependencies.
module rbc_serial_mult #(
    parameter int A_W = 40,
    parameter int B_W = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [P_W-1:0]   r_prod;   // upper part accumulates, lower part holds the remaining multiplier bits
    logic [A_W:0]     n_sum;

    assign n_sum = {1'b0, r_prod[P_W-1:B_W]} + (r_prod[0] ? {1'b0, i_a} : {(A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(B_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_prod <= {n_sum, r_prod[B_W-1:1]};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_prod = r_prod;

endmodule

>>> rtl/retry_backoff_controller_unit.sv
// retry_backoff_controller_unit: top level of the retry backoff controller.
// Instantiates rbc_cfg_regs and two rbc_serial_mult units; depends on rbc_pkg.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one attempt report per transaction:
//   breaker verdict, attempt outcome and a signed Q1.15 jitter sample. Output channel
//   (o_out_valid/i_out_ready) returns exactly one result per attempt. The config channel
//   (i_cfg_valid/o_cfg_ready, always ready) writes register i_cfg_index; write it only
//   while no attempt is in flight.
//   Success, blocked and exhausted results skip the multipliers and go from S_FIN
//   into the output register. A retry runs the jittered delay product and the base
//   growth product on two bit-serial multipliers side by side; the 25-bit jitter
//   multiplier sets the length, then S_CLAMP and S_FIN lead to the output register.
//   One attempt is processed at a time: the next can be taken in the cycle after the
//   result moves into the output register, and none is taken before that.
//   A stalled receiver holds the result in the output register; a finished attempt
//   waits in S_FIN, with ready low, until that register frees up.
//   Reset (synchronous, active low) loads register defaults and starts a new operation.
module retry_backoff_controller_unit import rbc_pkg::*; #(
    parameter int DELAY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [((DELAY_BITS > 16) ? DELAY_BITS : 16)-1:0] i_cfg_data,
    // attempt channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_breaker_allows,
    input  logic                              i_attempt_ok,
    input  logic signed [15:0]                i_jitter_sample,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_outcome,
    output logic [DELAY_BITS-1:0]             o_wait_ms,
    output logic [5:0]                        o_attempts_made,
    output logic [20:0]                       o_delay_sum,
    output logic                              o_note_success,
    output logic                              o_note_failure,
    output logic                              o_rollback_request,
    output logic                              o_finished
);

    localparam int CFG_W   = (DELAY_BITS > 16) ? DELAY_BITS : 16;
    localparam int BASE_W  = 40;                 // Q32.8 ms
    localparam int MU_W    = 25;                 // positive Q.23 multiplier
    localparam int M_W     = MU_W + 1;           // signed multiplier before the sign check
    localparam int PD_W    = BASE_W + MU_W;
    localparam int PG_W    = BASE_W + GROWTH_W;
    localparam int DLY_W   = PD_W - 31;
    localparam int ATT_W   = 6;
    localparam int SUM_W   = 21;
    localparam int TOT_W   = ((DELAY_BITS > SUM_W) ? DELAY_BITS : SUM_W) + 1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic signed [M_W-1:0] ONE_Q23 = M_W'(1 << 23);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_CLAMP,
        S_FIN
    } t_state;

    // configuration
    logic [LIMIT_W-1:0]    cfg_limit;
    logic [DELAY_BITS-1:0] cfg_first;
    logic [DELAY_BITS-1:0] cfg_cap;
    logic [GROWTH_W-1:0]   cfg_growth;
    logic [JIT_W-1:0]      cfg_jitter;
    logic                  cfg_breaker;

    // operation state
    t_state                r_state;
    logic [LIMIT_W-1:0]    r_attempt;
    logic [BASE_W-1:0]     r_base;
    logic [SUM_W-1:0]      r_total;

    // item in flight
    t_outcome              r_outcome;
    logic [ATT_W-1:0]      r_attempts;
    logic                  r_ns;
    logic                  r_nf;
    logic                  r_mpos;
    logic [MU_W-1:0]       r_mu;
    logic [DELAY_BITS-1:0] r_wait;

    // output register
    logic                  r_out_valid;
    t_outcome              r_out_outcome;
    logic [DELAY_BITS-1:0] r_out_wait;
    logic [ATT_W-1:0]      r_out_attempts;
    logic [SUM_W-1:0]      r_out_sum;
    logic                  r_out_ns;
    logic                  r_out_nf;
    logic                  r_out_rb;
    logic                  r_out_fin;

    // multipliers
    logic                  mul_start;
    logic                  dly_busy;
    logic                  grw_busy;
    logic [PD_W-1:0]       dly_prod;
    logic [PG_W-1:0]       grw_prod;

    // next values
    logic                  n_blocked;
    t_outcome              n_outcome;
    logic [ATT_W-1:0]      n_attempts;
    logic signed [M_W-1:0] n_sj;
    logic signed [M_W-1:0] n_m;
    logic [DLY_W-1:0]      n_dly_raw;
    logic [DELAY_BITS-1:0] n_wait;
    logic [BASE_W-1:0]     n_base;
    logic [TOT_W-1:0]      n_sum;
    logic [SUM_W-1:0]      n_total;
    logic                  out_free;

    rbc_cfg_regs #(
        .DELAY_BITS (DELAY_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_retry_limit (cfg_limit),
        .o_first_delay (cfg_first),
        .o_delay_cap   (cfg_cap),
        .o_growth      (cfg_growth),
        .o_jitter_span (cfg_jitter),
        .o_breaker_en  (cfg_breaker)
    );

    assign mul_start = (r_state == S_START);

    rbc_serial_mult #(
        .A_W (BASE_W),
        .B_W (MU_W)
    ) u_dly_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_base),
        .i_b     (r_mu),
        .o_busy  (dly_busy),
        .o_prod  (dly_prod)
    );

    rbc_serial_mult #(
        .A_W (BASE_W),
        .B_W (GROWTH_W)
    ) u_grw_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_base),
        .i_b     (cfg_growth),
        .o_busy  (grw_busy),
        .o_prod  (grw_prod)
    );

    // attempt classification at acceptance
    always_comb begin
        n_blocked = cfg_breaker && !i_breaker_allows;
        if (n_blocked) begin
            n_outcome = OUT_BLOCKED;
        end else if (i_attempt_ok) begin
            n_outcome = OUT_SUCCESS;
        end else if (r_attempt < cfg_limit) begin
            n_outcome = OUT_RETRY;
        end else begin
            n_outcome = OUT_EXHAUSTED;
        end
        n_attempts = n_blocked ? ATT_W'(r_attempt) : ATT_W'(r_attempt) + ATT_W'(1);
    end

    // jitter multiplier: 1.0 + sample * span in Q.23
    assign n_sj = $signed({{(M_W-16){i_jitter_sample[15]}}, i_jitter_sample})
                * $signed({{(M_W-JIT_W){1'b0}}, cfg_jitter});
    assign n_m  = n_sj + ONE_Q23;

    // delay = floor(base * mu / 2^31), clamped to the cap; zero when mu is not positive
    assign n_dly_raw = dly_prod[PD_W-1:31];
    always_comb begin
        if (!r_mpos) begin
            n_wait = '0;
        end else if (n_dly_raw > DLY_W'(cfg_cap)) begin
            n_wait = cfg_cap;
        end else begin
            n_wait = n_dly_raw[DELAY_BITS-1:0];
        end
    end

    // base growth: floor(base * factor / 256), saturating
    assign n_base = (|grw_prod[PG_W-1:BASE_W+8]) ? '1 : grw_prod[BASE_W+7:8];

    assign n_sum   = TOT_W'(r_total) + TOT_W'(r_wait);
    assign n_total = (n_sum > TOT_W'(SUM_MAX)) ? SUM_MAX : n_sum[SUM_W-1:0];

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_attempt      <= '0;
            r_base         <= '0;
            r_total        <= '0;
            r_outcome      <= OUT_RETRY;
            r_attempts     <= '0;
            r_ns           <= 1'b0;
            r_nf           <= 1'b0;
            r_mpos         <= 1'b0;
            r_mu           <= '0;
            r_wait         <= '0;
            r_out_valid    <= 1'b0;
            r_out_outcome  <= OUT_RETRY;
            r_out_wait     <= '0;
            r_out_attempts <= '0;
            r_out_sum      <= '0;
            r_out_ns       <= 1'b0;
            r_out_nf       <= 1'b0;
            r_out_rb       <= 1'b0;
            r_out_fin      <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_outcome  <= n_outcome;
                        r_attempts <= n_attempts;
                        r_ns       <= cfg_breaker && !n_blocked && i_attempt_ok;
                        r_nf       <= cfg_breaker && !n_blocked && !i_attempt_ok;
                        r_mpos     <= !n_m[M_W-1] && (n_m != '0);
                        r_mu       <= n_m[MU_W-1:0];
                        r_wait     <= '0;
                        // a new operation starts from the first delay
                        if (r_attempt == '0) begin
                            r_base  <= BASE_W'({cfg_first, 8'b0});
                            r_total <= '0;
                        end
                        r_state <= (n_outcome == OUT_RETRY) ? S_START : S_FIN;
                    end
                end
                S_START: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!dly_busy && !grw_busy) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_wait  <= n_wait;
                    r_base  <= n_base;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_outcome  <= r_outcome;
                        r_out_wait     <= r_wait;
                        r_out_attempts <= r_attempts;
                        r_out_sum      <= n_total;
                        r_out_ns       <= r_ns;
                        r_out_nf       <= r_nf;
                        r_out_rb       <= (r_outcome == OUT_EXHAUSTED);
                        r_out_fin      <= (r_outcome != OUT_RETRY);
                        if (r_outcome == OUT_RETRY) begin
                            r_attempt <= r_attempt + 1'b1;
                            r_total   <= n_total;
                        end else begin
                            r_attempt <= '0;
                            r_base    <= '0;
                            r_total   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_out_outcome;
    assign o_wait_ms          = r_out_wait;
    assign o_attempts_made    = r_out_attempts;
    assign o_delay_sum        = r_out_sum;
    assign o_note_success     = r_out_ns;
    assign o_note_failure     = r_out_nf;
    assign o_rollback_request = r_out_rb;
    assign o_finished         = r_out_fin;

`ifndef SYNTHESIS
    // multipliers must be idle whenever a new attempt can be taken
    a_mult_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!dly_busy && !grw_busy))
        else $error("multiplier busy while idle");

    a_retry_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome == OUT_RETRY) |-> (!o_finished && o_wait_ms <= cfg_cap))
        else $error("retry result ends operation or exceeds cap");

    a_final_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome != OUT_RETRY) |-> (o_finished && o_wait_ms == '0))
        else $error("final result with nonzero wait or not finished");

    a_rollback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rollback_request) |-> (o_outcome == OUT_EXHAUSTED && !o_note_success))
        else $error("rollback without exhaustion");
`endif

endmodule
